// ===== rtl/sfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_pkg
// Shared types, codes and helpers for the sprite FIFO merge and pixel mixer.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;

  // operation codes of an input word
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_MIX   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [2:0] CFG_BG_ENABLE     = 3'd0;
  localparam logic [2:0] CFG_SPRITE_ENABLE = 3'd1;
  localparam logic [2:0] CFG_BG_PALETTE    = 3'd2;
  localparam logic [2:0] CFG_OBJ_PALETTE0  = 3'd3;
  localparam logic [2:0] CFG_OBJ_PALETTE1  = 3'd4;

  // attribute byte bit positions
  localparam int unsigned FlagPal1   = 4;
  localparam int unsigned FlagFlip   = 5;
  localparam int unsigned FlagBehind = 7;

  // one FIFO slot
  typedef struct packed {
    logic [1:0] color;
    logic       use_pal1;
    logic       behind_bg;
  } slot_t;

  // per-row merge control shared by all lanes
  typedef struct packed {
    logic              en;
    logic              flip;
    logic              use_pal1;
    logic              behind_bg;
    logic [CntW-1:0]   count;   // pixels shown after cropping
    logic [PtrW-1:0]   skip;    // leading pixels cropped (mod depth)
    logic [PtrW-1:0]   read_ptr;
    logic [CntW-1:0]   fill;
  } push_ctl_t;

  // register file seen by the mixer
  typedef struct packed {
    logic       bg_enable;
    logic       sprite_enable;
    logic [7:0] bg_palette;
    logic [7:0] obj_palette0;
    logic [7:0] obj_palette1;
  } cfg_t;

  // pick a 2-bit shade out of a packed palette
  function automatic logic [1:0] lookup_shade(input logic [7:0] pal, input logic [1:0] color);
    logic [1:0] s;
    case (color)
      2'd0:    s = pal[1:0];
      2'd1:    s = pal[3:2];
      2'd2:    s = pal[5:4];
      2'd3:    s = pal[7:6];
      default: s = pal[1:0];
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/sfm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_lane
// One FIFO slot and its merge logic. The lane works out its position relative
// to the read pointer, picks its pixel out of the tile row and decides whether
// to append or to fill a transparent slot.
// ----------------------------------------------------------------------------
module sfm_lane (
  input  logic                          clk,
  input  logic [sfm_pkg::PtrW-1:0]      lane_id,
  input  sfm_pkg::push_ctl_t            ctl,
  input  logic [7:0]                    plane_low,
  input  logic [7:0]                    plane_high,
  output sfm_pkg::slot_t                slot
);
  import sfm_pkg::*;

  logic [PtrW-1:0] rel;
  logic [PtrW-1:0] bit_sel;
  logic            in_row;
  logic            append;
  logic [1:0]      px;
  logic            wr;

  // position of this slot inside the queue
  assign rel    = lane_id - ctl.read_ptr;
  assign in_row = {1'b0, rel} < ctl.count;
  assign append = {1'b0, rel} >= ctl.fill;

  // plane bit for this pixel, mirrored on horizontal flip
  assign bit_sel = ctl.flip ? (ctl.skip + rel) : (PtrW'(FifoDepth - 1) - (rel + ctl.skip));
  assign px      = {plane_high[bit_sel], plane_low[bit_sel]};

  // empty slots take any pixel, held slots only opaque over transparent
  assign wr = ctl.en && in_row && (append || (slot.color == 2'd0 && px != 2'd0));

  always_ff @(posedge clk) begin
    if (wr) begin
      slot.color     <= px;
      slot.use_pal1  <= ctl.use_pal1;
      slot.behind_bg <= ctl.behind_bg;
    end
  end

endmodule

// ===== rtl/sfm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_mixer
// Merges the head sprite pixel with the background colour and maps the
// winner through its palette.
// ----------------------------------------------------------------------------
module sfm_mixer (
  input  sfm_pkg::cfg_t   cfg,
  input  logic            has_pixel,
  input  sfm_pkg::slot_t  head,
  input  logic [1:0]      bg_color,
  output logic [1:0]      shade
);
  import sfm_pkg::*;

  logic [1:0] bg_shade;
  logic [1:0] obj_shade;
  logic       hidden;
  logic       show_obj;

  assign bg_shade  = cfg.bg_enable ? lookup_shade(cfg.bg_palette, bg_color) : 2'd0;
  assign obj_shade = lookup_shade(head.use_pal1 ? cfg.obj_palette1 : cfg.obj_palette0,
                                  head.color);

  // priority: sprite behind an enabled, non-zero background loses
  assign hidden   = head.behind_bg && cfg.bg_enable && (bg_color != 2'd0);
  assign show_obj = has_pixel && cfg.sprite_enable && (head.color != 2'd0) && !hidden;
  assign shade    = show_obj ? obj_shade : bg_shade;

endmodule

// ===== rtl/sfm_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfm_out_buf
// Two-entry output register with skid stage for the shade words.
// ----------------------------------------------------------------------------
module sfm_out_buf (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [1:0] push_shade,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] shade
);

  logic       skid_valid;
  logic [1:0] skid_shade;

  assign space = !skid_valid;

  // main register drains into the port, skid catches a word while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
        skid_shade <= push_shade;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      shade      <= skid_shade;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
      if (push) begin
        shade <= push_shade;
      end
    end
  end

endmodule

// ===== rtl/sprite_fifo_merge_and_pixel_mixer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_fifo_merge_and_pixel_mixer_core
// Eight-slot sprite pixel FIFO: row merge over eight parallel slot lanes,
// pixel mix against the background, and line-end clear.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_ready, operation, plane_low,        | in
//           | plane_high, sprite_x, sprite_flags, bg_color    |
//   out     | out_valid/out_ready, shade                      | out
//   cfg     | cfg_we, cfg_index, cfg_data                     | in
//
// One input word per cycle while in_ready is high; a push merges all eight
// lanes at once. A mix word's shade is registered before the out port.
// in_ready drops only while two shade words wait in the output buffer.
// Reset clears pointers, fill count and output valids and loads config
// defaults; slot contents are not reset and are only read once written.
// ----------------------------------------------------------------------------
module sprite_fifo_merge_and_pixel_mixer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] operation,
  input  logic [7:0] plane_low,
  input  logic [7:0] plane_high,
  input  logic [7:0] sprite_x,
  input  logic [7:0] sprite_flags,
  input  logic [1:0] bg_color,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] shade,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sfm_pkg::*;

  cfg_t            cfg;
  logic [PtrW-1:0] read_ptr;
  logic [CntW-1:0] fill;
  logic [PtrW-1:0] read_ptr_next;
  logic [CntW-1:0] fill_next;
  logic [CntW-1:0] row_count;
  logic [CntW-1:0] row_skip;
  logic            accept;
  logic            space;
  logic            do_mix;
  logic [1:0]      mix_shade;
  op_t             op;
  push_ctl_t       ctl;
  slot_t           slots [FifoDepth];

  assign op       = op_t'(operation);
  assign in_ready = space;
  assign accept   = in_valid && in_ready;
  assign do_mix   = accept && (op == OP_MIX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bg_enable     <= 1'b1;
      cfg.sprite_enable <= 1'b0;
      cfg.bg_palette    <= 8'hFC;
      cfg.obj_palette0  <= 8'h00;
      cfg.obj_palette1  <= 8'h00;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BG_ENABLE:     cfg.bg_enable     <= cfg_data[0];
        CFG_SPRITE_ENABLE: cfg.sprite_enable <= cfg_data[0];
        CFG_BG_PALETTE:    cfg.bg_palette    <= cfg_data;
        CFG_OBJ_PALETTE0:  cfg.obj_palette0  <= cfg_data;
        CFG_OBJ_PALETTE1:  cfg.obj_palette1  <= cfg_data;
        default:           ;
      endcase
    end
  end

  // crop: positions below the depth show only x pixels
  assign row_count = (sprite_x >= 8'(FifoDepth)) ? CntW'(FifoDepth) : sprite_x[CntW-1:0];
  assign row_skip  = CntW'(FifoDepth) - row_count;

  always_comb begin
    ctl.en        = accept && (op == OP_PUSH);
    ctl.flip      = sprite_flags[FlagFlip];
    ctl.use_pal1  = sprite_flags[FlagPal1];
    ctl.behind_bg = sprite_flags[FlagBehind];
    ctl.count     = row_count;
    ctl.skip      = row_skip[PtrW-1:0];
    ctl.read_ptr  = read_ptr;
    ctl.fill      = fill;
  end

  // slot lanes
  for (genvar g = 0; g < FifoDepth; g++) begin : g_lane
    sfm_lane u_lane (
      .clk        (clk),
      .lane_id    (PtrW'(g)),
      .ctl        (ctl),
      .plane_low  (plane_low),
      .plane_high (plane_high),
      .slot       (slots[g])
    );
  end

  // head pixel mix
  sfm_mixer u_mixer (
    .cfg       (cfg),
    .has_pixel (fill != '0),
    .head      (slots[read_ptr]),
    .bg_color  (bg_color),
    .shade     (mix_shade)
  );

  // pointer and fill count update
  always_comb begin
    read_ptr_next = read_ptr;
    fill_next     = fill;
    if (accept) begin
      case (op)
        OP_PUSH: begin
          if (row_count > fill) begin
            fill_next = row_count;
          end
        end
        OP_MIX: begin
          if (fill != '0) begin
            read_ptr_next = read_ptr + PtrW'(1);
            fill_next     = fill - CntW'(1);
          end
        end
        OP_CLEAR: begin
          read_ptr_next = '0;
          fill_next     = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr <= '0;
      fill     <= '0;
    end else begin
      read_ptr <= read_ptr_next;
      fill     <= fill_next;
    end
  end

  // result words
  sfm_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (do_mix),
    .push_shade (mix_shade),
    .space      (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .shade      (shade)
  );

endmodule
